// File: src/triangular_system_solver_assert.svh
// Assertion macros for the triangular system solver
`ifndef TRIANGULAR_SYSTEM_SOLVER_ASSERT_SVH
`define TRIANGULAR_SYSTEM_SOLVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TSS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("%m: check failed");
`define TSS_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("%m: check failed");
`else
`define TSS_ASSERT_IMP(label, clk, rst_n, a, c)
`define TSS_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// File: src/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Types and constants shared by the triangular system solver.
// ----------------------------------------------------------------------------
`default_nettype none
package tss_pkg;
    localparam int MAX_UNKNOWNS = 16;
    localparam int FRAC_BITS    = 16;
    localparam int IDX_W        = $clog2(MAX_UNKNOWNS);
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    localparam logic [1:0] OP_LOAD_COEF = 2'd0;
    localparam logic [1:0] OP_LOAD_RHS  = 2'd1;
    localparam logic [1:0] OP_START     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_IN_USE = 1'd1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic [3:0]         unknown_index;
        logic signed [31:0] solution_value;
        logic               zero_pivot;
        logic               saturated;
        logic               last;
    } out_word_t;
endpackage
`default_nettype wire

// File: src/triangular_system_solver.sv
// ----------------------------------------------------------------------------
// triangular_system_solver
// Fixed-point triangular solve by forward or back substitution.
// ----------------------------------------------------------------------------
// Load words are accepted one per cycle while the block is idle. A start word
// runs the solve on one shared 32x32 multiplier and a bit-serial divider.
// Each multiply-add runs through three steps: memory read, multiply and
// accumulate. Each unknown also needs row setup, the 64-step division and an
// output step, and each result waits until the receiver takes it. No new word
// is accepted until the last result has been taken.
`default_nettype none
`include "triangular_system_solver_assert.svh"
module triangular_system_solver (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tss_pkg::in_word_t      in_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output tss_pkg::out_word_t          out_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [tss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tss_pkg::*;

    localparam int N_W = $clog2(MAX_UNKNOWNS + 1);
    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = -64'sh7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE, S_ROW, S_RD, S_MUL, S_ACC, S_DRD, S_DIV, S_WAIT, S_OUT
    } state_t;

    logic [31:0] coef_mem [MAX_UNKNOWNS*MAX_UNKNOWNS];
    logic [31:0] rhs_mem  [MAX_UNKNOWNS];
    logic [31:0] sol_mem  [MAX_UNKNOWNS];

    state_t state_reg;
    logic   upper_reg;
    logic [4:0] size_reg;
    logic [IDX_W-1:0] n1_reg;      // last index of this solve
    logic [IDX_W-1:0] i_reg, j_reg;
    logic [N_W-1:0]   k_reg;       // unknowns done
    logic signed [63:0] acc_reg, prod_reg;
    logic signed [31:0] ca_reg, sb_reg, rhs_rd_reg, d_reg;
    logic clip_reg;
    logic out_valid_reg;
    out_word_t out_reg;
    logic div_start, div_done;
    logic signed [64:0] quo;
    logic [IDX_W-1:0] coef_j;
    logic signed [63:0] diff;
    logic signed [64:0] diff_w;
    logic has_terms;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    // diagonal word sits in ca_reg during S_DIV
    assign div_start = (state_reg == S_DIV);

    // terms remain for row i starting at j
    always_comb
    begin
        if (upper_reg)
            has_terms = (i_reg != n1_reg) && (j_reg <= n1_reg) && (j_reg > i_reg);
        else
            has_terms = (j_reg < i_reg);
    end

    assign coef_j = (state_reg == S_DRD || state_reg == S_ROW) ? i_reg : j_reg;
    assign diff_w = {acc_reg[63], acc_reg} - {prod_reg[63], prod_reg};
    assign diff = (diff_w > 65'sh0_7FFF_FFFF_FFFF_FFFF) ? ACC_MAX :
                  (diff_w < -65'sh0_7FFF_FFFF_FFFF_FFFF) ? ACC_MIN : diff_w[63:0];

    tss_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(acc_reg), .divisor(ca_reg), .done(div_done), .quotient(quo)
    );

    // memories
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && in_data.operation == OP_LOAD_COEF)
            coef_mem[{in_data.row, in_data.col}] <= in_data.value;
        if (in_valid && in_ready && in_data.operation == OP_LOAD_RHS)
            rhs_mem[in_data.row] <= in_data.value;
        if (state_reg == S_OUT)
            sol_mem[i_reg] <= out_reg.solution_value;
        ca_reg     <= coef_mem[{i_reg, coef_j}];
        sb_reg     <= sol_mem[j_reg];
        rhs_rd_reg <= rhs_mem[i_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            upper_reg     <= 1'b1;
            size_reg      <= 5'd16;
            out_valid_reg <= 1'b0;
            n1_reg <= '0; i_reg <= '0; j_reg <= '0; k_reg <= '0;
            clip_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        if (cfg_index == REG_UPPER_MODE)
                            upper_reg <= cfg_data[0];
                        else if (cfg_index == REG_SIZE_IN_USE)
                            size_reg <= cfg_data[4:0];
                    end
                    if (in_valid && in_data.operation == OP_START)
                    begin
                        logic [4:0] n;
                        n = (size_reg == 5'd0) ? 5'd1 :
                            (size_reg > 5'(MAX_UNKNOWNS)) ? 5'(MAX_UNKNOWNS) : size_reg;
                        n1_reg <= IDX_W'(n - 5'd1);
                        i_reg  <= upper_reg ? IDX_W'(n - 5'd1) : '0;
                        k_reg  <= '0;
                        state_reg <= S_ROW;
                    end
                end
                S_ROW:
                begin
                    // rhs read in flight; j starts after i (upper) or at 0
                    j_reg    <= upper_reg ? i_reg + IDX_W'(1) : '0;
                    clip_reg <= 1'b0;
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    if (j_reg == (upper_reg ? i_reg + IDX_W'(1) : '0))
                        acc_reg <= 64'(rhs_rd_reg) <<< FRAC_BITS;
                    state_reg <= has_terms ? S_MUL : S_DRD;
                end
                S_MUL:
                begin
                    prod_reg  <= ca_reg * sb_reg;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg <= diff;
                    if (diff != diff_w[63:0] || diff_w[64] != diff_w[63])
                        clip_reg <= 1'b1;
                    j_reg <= j_reg + IDX_W'(1);
                    state_reg <= S_RD;
                end
                S_DRD:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    d_reg <= ca_reg;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_done)
                    begin
                        out_reg.unknown_index <= 4'(i_reg);
                        out_reg.last <= (k_reg == N_W'(n1_reg));
                        if (d_reg == 32'sd0)
                        begin
                            out_reg.solution_value <= '0;
                            out_reg.zero_pivot <= 1'b1;
                            out_reg.saturated  <= 1'b0;
                        end
                        else if (quo > 65'sh0_7FFF_FFFF)
                        begin
                            out_reg.solution_value <= 32'sh7FFF_FFFF;
                            out_reg.zero_pivot <= 1'b0;
                            out_reg.saturated  <= 1'b1;
                        end
                        else if (quo < -65'sh0_8000_0000)
                        begin
                            out_reg.solution_value <= 32'sh8000_0000;
                            out_reg.zero_pivot <= 1'b0;
                            out_reg.saturated  <= 1'b1;
                        end
                        else
                        begin
                            out_reg.solution_value <= quo[31:0];
                            out_reg.zero_pivot <= 1'b0;
                            out_reg.saturated  <= clip_reg;
                        end
                        out_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (k_reg == N_W'(n1_reg))
                            state_reg <= S_IDLE;
                        else
                        begin
                            k_reg <= k_reg + N_W'(1);
                            i_reg <= upper_reg ? i_reg - IDX_W'(1) : i_reg + IDX_W'(1);
                            state_reg <= S_ROW;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `TSS_ASSERT_IMP(a_out_only_in_out, clk, rst_n, out_valid_reg, state_reg == S_OUT)
    `TSS_ASSERT_IMP(a_no_in_busy, clk, rst_n, state_reg != S_IDLE, !in_ready)
    `TSS_ASSERT_NXT(a_last_ends, clk, rst_n, out_valid && out_ready && out_reg.last,
                    state_reg == S_IDLE)
    `TSS_ASSERT_IMP(a_zp_no_sat, clk, rst_n, out_valid && out_reg.zero_pivot,
                    !out_reg.saturated && out_reg.solution_value == 32'sd0)
endmodule
`default_nettype wire

// File: src/tss_divider.sv
// ----------------------------------------------------------------------------
// tss_divider
// Radix-2 restoring signed divider, 64 by 32 bits, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module tss_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [63:0] dividend,
    input  wire logic signed [31:0] divisor,
    output logic                    done,
    output logic signed [64:0]      quotient
);
    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [63:0] a_mag;

    assign a_mag = dividend[63] ? (64'd0 - dividend) : dividend;
    assign trial = {r_reg, q_reg[63]} - {2'b00, d_reg};

    always_comb
    begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg; cnt_next = cnt_reg;
        neg_next = neg_reg; busy_next = busy_reg; done_next = 1'b0;
        if (start)
        begin
            q_next = a_mag;
            r_next = '0;
            d_next = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next = dividend[63] ^ divisor[31];
            cnt_next = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                r_next = trial[32:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[31:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            neg_reg  <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quotient = neg_reg ? (65'sd0 - $signed({1'b0, q_reg})) : $signed({1'b0, q_reg});
endmodule
`default_nettype wire

// File: tb/sv/triangular_system_solver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangular_system_solver_tb
// Loads coefficient and rhs words, runs forward and back substitution solves
// at several sizes and modes, and checks every solved unknown against a
// Q16.16 substitution predictor kept alongside the block. The sender idles and
// the receiver stalls at random, first in separate phases and then together.
// ----------------------------------------------------------------------------
`default_nettype none
module triangular_system_solver_tb;
    import tss_pkg::*;

    localparam int  LIMIT     = 1000000;
    localparam int  ITEM_GOAL = 310;
    localparam int  SETTLE    = 40;
    localparam longint SUM_MAX = 64'sh7fffffffffffffff;
    localparam longint SUM_MIN = -64'sh7fffffffffffffff;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    in_word_t  in_data = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    out_word_t out_data;
    logic      out_valid;
    logic      out_ready = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    triangular_system_solver i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
        .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic signed [31:0] coef_mem [16][16];
    logic signed [31:0] rhs_mem [16];
    logic signed [31:0] x_mem [16];
    logic               cfg_upper = 1'b1;
    logic [4:0]         cfg_size = 5'd16;

    // stimulus-side bookkeeping: which entries have been loaded
    bit coef_loaded [16][16];
    bit rhs_loaded [16];

    in_word_t  pending_words [$];
    out_word_t expected_unknowns [$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        fails = 0;
    int        items_queued = 0;
    int        cycles = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fails++;
    endtask

    // substitution solve of the whole system, one expected word per unknown
    task automatic solve_system();
        int     n;
        int     i;
        int     j0;
        int     j1;
        longint acc;
        longint prod;
        longint quo;
        longint dia;
        bit     clip;
        out_word_t w;
        n = (cfg_size == 0) ? 1 : (cfg_size > MAX_UNKNOWNS) ? MAX_UNKNOWNS : cfg_size;
        for (int k = 0; k < n; k++)
        begin
            i = cfg_upper ? n - 1 - k : k;
            j0 = cfg_upper ? i + 1 : 0;
            j1 = cfg_upper ? n : i;
            clip = 1'b0;
            acc = longint'(rhs_mem[i]) * 65536;
            for (int j = j0; j < j1; j++)
            begin
                prod = longint'(coef_mem[i][j]) * longint'(x_mem[j]);
                if (prod > 0 && acc < SUM_MIN + prod)
                begin
                    acc = SUM_MIN;
                    clip = 1'b1;
                end
                else if (prod < 0 && acc > SUM_MAX + prod)
                begin
                    acc = SUM_MAX;
                    clip = 1'b1;
                end
                else
                    acc = acc - prod;
            end
            dia = longint'(coef_mem[i][i]);
            w = '0;
            if (dia == 0)
            begin
                quo = 0;
                clip = 1'b0;
                w.zero_pivot = 1'b1;
            end
            else
            begin
                quo = acc / dia;
                if (quo > 64'sd2147483647)
                begin
                    quo = 64'sd2147483647;
                    clip = 1'b1;
                end
                else if (quo < -64'sd2147483648)
                begin
                    quo = -64'sd2147483648;
                    clip = 1'b1;
                end
            end
            x_mem[i] = quo[31:0];
            w.unknown_index = i[3:0];
            w.solution_value = quo[31:0];
            w.saturated = clip;
            w.last = (k == n - 1);
            expected_unknowns.push_back(w);
        end
    endtask

    task automatic absorb_word(input in_word_t w);
        case (w.operation)
            OP_LOAD_COEF: coef_mem[w.row][w.col] = w.value;
            OP_LOAD_RHS:  rhs_mem[w.row] = w.value;
            OP_START:     solve_system();
            default: ;
        endcase
    endtask

    // sender: one word per handshake, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                absorb_word(in_data);
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data <= pending_words.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: check each result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_unknowns.size() == 0)
                    report("unexpected word, index", out_data.unknown_index, -1);
                else
                begin
                    out_word_t e;
                    e = expected_unknowns.pop_front();
                    if (out_data.unknown_index !== e.unknown_index)
                        report("unknown_index", out_data.unknown_index, e.unknown_index);
                    if (out_data.solution_value !== e.solution_value)
                        report("solution_value", out_data.solution_value,
                               e.solution_value);
                    if (out_data.zero_pivot !== e.zero_pivot)
                        report("zero_pivot", out_data.zero_pivot, e.zero_pivot);
                    if (out_data.saturated !== e.saturated)
                        report("saturated", out_data.saturated, e.saturated);
                    if (out_data.last !== e.last)
                        report("last", out_data.last, e.last);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("triangular_system_solver_tb failed");
            $finish;
        end
    end

    task automatic wait_idle();
        @(posedge clk);
        while (pending_words.size() != 0 || in_valid || expected_unknowns.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_UPPER_MODE)
            cfg_upper = data[0];
        else
            cfg_size = data[4:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(input bit up, input int size);
        write_reg(REG_UPPER_MODE, {31'($urandom()), up});
        write_reg(REG_SIZE_IN_USE, ($urandom() & ~32'h1f) | size);
    endtask

    task automatic queue_word(input logic [1:0] op, input int r, input int c,
                              input logic [31:0] v);
        in_word_t w;
        w.operation = op;
        w.row = r[3:0];
        w.col = c[3:0];
        w.value = v;
        pending_words.push_back(w);
        if (op == OP_LOAD_COEF)
            coef_loaded[r][c] = 1'b1;
        if (op == OP_LOAD_RHS)
            rhs_loaded[r] = 1'b1;
        if (op != 2'd3)
            items_queued++;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(9))
            0: return $urandom();
            1: case ($urandom_range(4))
                   0: return 32'h7fffffff;
                   1: return 32'h80000000;
                   2: return 32'h0;
                   3: return 32'hffffffff;
                   default: return 32'h00000001;
               endcase
            default: return $urandom_range(32'h80000) - 32'h40000;
        endcase
    endfunction

    function automatic logic [31:0] rand_diag();
        if ($urandom_range(11) == 0)
            return 32'h0;
        if ($urandom_range(5) == 0)
            return rand_value();
        // roughly 0.5 .. 4.0 with random sign
        return $urandom_range(1) ? $urandom_range(32'h40000, 32'h8000)
                                 : -$urandom_range(32'h40000, 32'h8000);
    endfunction

    // load what the solve will read (missing entries always, others sometimes)
    task automatic load_and_solve(input int rewrite_pct);
        int n;
        n = (cfg_size == 0) ? 1 : (cfg_size > MAX_UNKNOWNS) ? MAX_UNKNOWNS : cfg_size;
        for (int i = 0; i < n; i++)
        begin
            if (!rhs_loaded[i] || $urandom_range(99) < rewrite_pct)
                queue_word(OP_LOAD_RHS, i, $urandom_range(15), rand_value());
            if (!coef_loaded[i][i] || $urandom_range(99) < rewrite_pct)
                queue_word(OP_LOAD_COEF, i, i, rand_diag());
            for (int j = (cfg_upper ? i + 1 : 0); j < (cfg_upper ? n : i); j++)
                if (!coef_loaded[i][j] || $urandom_range(99) < rewrite_pct)
                    queue_word(OP_LOAD_COEF, i, j, rand_value());
            if ($urandom_range(19) == 0)
                queue_word(2'd3, $urandom_range(15), $urandom_range(15), $urandom());
            if ($urandom_range(19) == 0)
                queue_word(OP_LOAD_COEF, $urandom_range(15), $urandom_range(15),
                           rand_value());
        end
        if ($urandom_range(9) != 0)
            queue_word(OP_START, $urandom_range(15), $urandom_range(15), $urandom());
        if ($urandom_range(9) == 0)
            queue_word(OP_START, $urandom_range(15), $urandom_range(15), $urandom());
    endtask

    initial
    begin
        int sz;
        int pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: single unknown extremes
        set_mode(1'b1, 1);
        queue_word(OP_LOAD_RHS, 0, 0, 32'h7fffffff);
        queue_word(OP_LOAD_COEF, 0, 0, 32'h00000001);
        queue_word(OP_START, 0, 0, 32'h0);
        queue_word(OP_LOAD_COEF, 0, 0, 32'h0);
        queue_word(OP_START, 0, 0, 32'h0);
        queue_word(OP_LOAD_RHS, 0, 0, 32'h80000000);
        queue_word(OP_LOAD_COEF, 0, 0, 32'hffffffff);
        queue_word(OP_START, 0, 0, 32'h0);
        queue_word(2'd3, 15, 15, 32'hffffffff);
        queue_word(OP_LOAD_RHS, 0, 0, 32'h00010000);
        queue_word(OP_LOAD_COEF, 0, 0, 32'h00010000);
        queue_word(OP_START, 15, 15, 32'hffffffff);
        // forward substitution, two unknowns, large products
        set_mode(1'b0, 2);
        queue_word(OP_LOAD_COEF, 0, 0, 32'h00000001);
        queue_word(OP_LOAD_COEF, 1, 0, 32'h80000000);
        queue_word(OP_LOAD_COEF, 1, 1, 32'h7fffffff);
        queue_word(OP_LOAD_RHS, 1, 0, 32'h80000000);
        queue_word(OP_START, 0, 0, 32'h0);

        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            while (items_queued < (phase + 1) * ITEM_GOAL / 4)
            begin
                pick = $urandom_range(29);
                case (pick)
                    0: sz = 16;
                    1: sz = 31;
                    2: sz = 0;
                    3: sz = 17;
                    default: sz = $urandom_range(5, 1);
                endcase
                set_mode($urandom_range(1), sz);
                load_and_solve(pick < 4 ? 10 : 60);
            end
        end

        wait_idle();
        repeat (100) @(posedge clk);
        if (fails == 0)
            $display("triangular_system_solver_tb passed");
        else
            $display("triangular_system_solver_tb failed");
        $finish;
    end
endmodule
`default_nettype wire
